[rtl/core/pidc_pkg.sv]
// ----------------------------------------------------------------------------
// PID controller package
// Widths, configuration and word types, register indexes and command codes
// shared by the PID controller modules.
// ----------------------------------------------------------------------------
package pidc_pkg;

   // Signal and fixed-point format
   localparam int SIGNAL_BITS   = 16;
   localparam int FRACTION_BITS = 16;

   // Fixed register and timestamp widths
   localparam int GAIN_W   = 32;
   localparam int LIMIT_W  = 16;
   localparam int PERIOD_W = 16;
   localparam int TIME_W   = 32;

   // Datapath widths
   localparam int DIFF_W  = SIGNAL_BITS + 1;
   localparam int PROD_W  = GAIN_W + DIFF_W;
   localparam int SUM_W   = PROD_W + 3;
   localparam int INTEG_W = LIMIT_W + FRACTION_BITS;

   // Register port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_GAIN_P        = 3'd0,
      REG_GAIN_I        = 3'd1,
      REG_GAIN_D        = 3'd2,
      REG_LIMIT_LOW     = 3'd3,
      REG_LIMIT_HIGH    = 3'd4,
      REG_SAMPLE_PERIOD = 3'd5,
      REG_AUTO_MODE     = 3'd6,
      REG_P_ON_MEAS     = 3'd7
   } reg_idx_type;

   // Input word commands
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_INIT   = 1'b1;

   typedef struct packed {
      logic signed [GAIN_W-1:0]  gain_p;
      logic signed [GAIN_W-1:0]  gain_i;
      logic signed [GAIN_W-1:0]  gain_d;
      logic signed [LIMIT_W-1:0] limit_low;
      logic signed [LIMIT_W-1:0] limit_high;
      logic [PERIOD_W-1:0]       sample_period;
      logic                      auto_mode;
      logic                      p_on_measurement;
   } cfg_type;

   typedef struct packed {
      logic                          cmd;
      logic [TIME_W-1:0]             now_ms;
      logic signed [SIGNAL_BITS-1:0] measurement;
      logic signed [SIGNAL_BITS-1:0] setpoint;
      logic signed [SIGNAL_BITS-1:0] init_output;
   } req_item_type;

   typedef struct packed {
      logic signed [SIGNAL_BITS-1:0] drive;
      logic                          updated;
   } rsp_item_type;

endpackage

[rtl/core/pidc_csr.sv]
// ----------------------------------------------------------------------------
// PID controller register file
// Holds gains, limits, sample period and mode bits behind an APB-style port.
// ----------------------------------------------------------------------------
module pidc_csr import pidc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type     cfg_ff;
   cfg_type     cfg_in;
   reg_idx_type reg_idx;
   logic        wr_en;

   assign pready  = 1'b1;
   assign reg_idx = reg_idx_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en   = psel && penable && pwrite && pready;

   // Decode a write into the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_GAIN_P:        cfg_in.gain_p           = pwdata[GAIN_W-1:0];
            REG_GAIN_I:        cfg_in.gain_i           = pwdata[GAIN_W-1:0];
            REG_GAIN_D:        cfg_in.gain_d           = pwdata[GAIN_W-1:0];
            REG_LIMIT_LOW:     cfg_in.limit_low        = pwdata[LIMIT_W-1:0];
            REG_LIMIT_HIGH:    cfg_in.limit_high       = pwdata[LIMIT_W-1:0];
            REG_SAMPLE_PERIOD: cfg_in.sample_period    = pwdata[PERIOD_W-1:0];
            REG_AUTO_MODE:     cfg_in.auto_mode        = pwdata[0];
            REG_P_ON_MEAS:     cfg_in.p_on_measurement = pwdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold the register values
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p           <= '0;
         cfg_ff.gain_i           <= '0;
         cfg_ff.gain_d           <= '0;
         cfg_ff.limit_low        <= LIMIT_W'(-32768);
         cfg_ff.limit_high       <= LIMIT_W'(32767);
         cfg_ff.sample_period    <= PERIOD_W'(100);
         cfg_ff.auto_mode        <= 1'b0;
         cfg_ff.p_on_measurement <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the addressed register, zero filled above its width
   always_comb begin
      unique case (reg_idx)
         REG_GAIN_P:        prdata = CSR_DATA_W'(cfg_ff.gain_p);
         REG_GAIN_I:        prdata = CSR_DATA_W'(cfg_ff.gain_i);
         REG_GAIN_D:        prdata = CSR_DATA_W'(cfg_ff.gain_d);
         REG_LIMIT_LOW:     prdata = {{(CSR_DATA_W-LIMIT_W){1'b0}}, cfg_ff.limit_low};
         REG_LIMIT_HIGH:    prdata = {{(CSR_DATA_W-LIMIT_W){1'b0}}, cfg_ff.limit_high};
         REG_SAMPLE_PERIOD: prdata = {{(CSR_DATA_W-PERIOD_W){1'b0}}, cfg_ff.sample_period};
         REG_AUTO_MODE:     prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.auto_mode};
         REG_P_ON_MEAS:     prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.p_on_measurement};
         default:           prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

[rtl/core/pidc_datapath.sv]
// ----------------------------------------------------------------------------
// PID controller datapath
// Computes one control step from the registered input word and keeps the
// controller state (integrator, previous measurement and time, held drive).
// ----------------------------------------------------------------------------
module pidc_datapath import pidc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         step,
   input  req_item_type item,
   output rsp_item_type result
);

   logic signed [INTEG_W-1:0]     integ_ff, integ_in;
   logic signed [SIGNAL_BITS-1:0] prev_meas_ff, prev_meas_in;
   logic [TIME_W-1:0]             prev_time_ff, prev_time_in;
   logic                          primed_ff, primed_in;
   logic signed [SIGNAL_BITS-1:0] held_ff, held_in;

   logic [TIME_W-1:0]             elapsed;
   logic                          is_init;
   logic                          do_update;
   logic signed [DIFF_W-1:0]      err;
   logic signed [DIFF_W-1:0]      dmeas;
   logic signed [PROD_W-1:0]      prod_ie, prod_pe, prod_pd, prod_dd;
   logic signed [SUM_W-1:0]       acc, drv, init_fix;
   logic signed [INTEG_W-1:0]     integ_upd, integ_init, drv_clamped;
   logic signed [SIGNAL_BITS-1:0] drive_new;

   // Clamp a wide fixed-point value to the limits; the upper limit wins
   function automatic logic signed [INTEG_W-1:0] clamp_fix(
      input logic signed [SUM_W-1:0]   v,
      input logic signed [LIMIT_W-1:0] lo,
      input logic signed [LIMIT_W-1:0] hi
   );
      logic signed [SUM_W-1:0]   lo_f;
      logic signed [SUM_W-1:0]   hi_f;
      logic signed [INTEG_W-1:0] r;
      lo_f = SUM_W'(lo) <<< FRACTION_BITS;
      hi_f = SUM_W'(hi) <<< FRACTION_BITS;
      if (v > hi_f) begin
         r = INTEG_W'(hi_f);
      end else if (v < lo_f) begin
         r = INTEG_W'(lo_f);
      end else begin
         r = INTEG_W'(v);
      end
      return r;
   endfunction

   // Decide whether this word runs an update
   assign is_init   = (item.cmd == CMD_INIT);
   assign elapsed   = item.now_ms - prev_time_ff;
   assign do_update = !is_init && cfg.auto_mode &&
                      (!primed_ff || (elapsed >= TIME_W'(cfg.sample_period)));

   // Error and measurement change
   assign err   = DIFF_W'(item.setpoint) - DIFF_W'(item.measurement);
   assign dmeas = DIFF_W'(item.measurement) - DIFF_W'(prev_meas_ff);

   // Four independent gain products, exact at the fixed-point scale
   assign prod_ie = $signed(cfg.gain_i) * $signed(err);
   assign prod_pe = $signed(cfg.gain_p) * $signed(err);
   assign prod_pd = $signed(cfg.gain_p) * $signed(dmeas);
   assign prod_dd = $signed(cfg.gain_d) * $signed(dmeas);

   // Integrator step, less the proportional term on measurement change if selected, clamped to the limits
   assign acc = SUM_W'(integ_ff) + SUM_W'(prod_ie)
              - (cfg.p_on_measurement ? SUM_W'(prod_pd) : SUM_W'(0));
   assign integ_upd = clamp_fix(acc, cfg.limit_low, cfg.limit_high);

   // Drive: integrator, proportional term on error if selected, minus derivative
   assign drv = SUM_W'(integ_upd)
              + (cfg.p_on_measurement ? SUM_W'(0) : SUM_W'(prod_pe))
              - SUM_W'(prod_dd);
   assign drv_clamped = clamp_fix(drv, cfg.limit_low, cfg.limit_high);
   assign drive_new   = SIGNAL_BITS'(drv_clamped >>> FRACTION_BITS);

   // Bumpless initialise value
   assign init_fix   = SUM_W'(item.init_output) <<< FRACTION_BITS;
   assign integ_init = clamp_fix(init_fix, cfg.limit_low, cfg.limit_high);

   // Next state
   always_comb begin
      integ_in     = integ_ff;
      prev_meas_in = prev_meas_ff;
      prev_time_in = prev_time_ff;
      primed_in    = primed_ff;
      held_in      = held_ff;
      if (step) begin
         if (is_init) begin
            integ_in     = integ_init;
            prev_meas_in = item.measurement;
         end else if (do_update) begin
            integ_in     = integ_upd;
            prev_meas_in = item.measurement;
            prev_time_in = item.now_ms;
            primed_in    = 1'b1;
            held_in      = drive_new;
         end
      end
   end

   // Hold the controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff     <= '0;
         prev_meas_ff <= '0;
         prev_time_ff <= '0;
         primed_ff    <= 1'b0;
         held_ff      <= '0;
      end else begin
         integ_ff     <= integ_in;
         prev_meas_ff <= prev_meas_in;
         prev_time_ff <= prev_time_in;
         primed_ff    <= primed_in;
         held_ff      <= held_in;
      end
   end

   // Result word: new drive on an update, else the held one
   assign result.drive   = do_update ? drive_new : held_ff;
   assign result.updated = do_update;

endmodule

[rtl/core/pid_controller_unit.sv]
// ----------------------------------------------------------------------------
// PID controller unit
// Each accepted word goes into an input register, is computed in one pass
// through the datapath and lands in a result register. One word per clock is
// sustained while the result channel does not stall; the result register
// loads when its word advances out of the input register, and the result
// word is offered from that register. The integrator and previous-measurement
// state close their loop within the combinational datapath pass, so
// consecutive samples never wait on each other.
// The input stalls only while its register is full and the result register
// is full and stalled. Configuration is written through the APB-style port
// at byte address 4*index and should be changed only while the unit is idle.
// ----------------------------------------------------------------------------
module pid_controller_unit import pidc_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   // Input channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic [TIME_W-1:0]             req_now_ms,
   input  logic signed [SIGNAL_BITS-1:0] req_measurement,
   input  logic signed [SIGNAL_BITS-1:0] req_setpoint,
   input  logic signed [SIGNAL_BITS-1:0] req_init_output,
   // Result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SIGNAL_BITS-1:0] rsp_drive,
   output logic                          rsp_updated,
   // Register port
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [CSR_ADDR_W-1:0]         paddr,
   input  logic [CSR_DATA_W-1:0]         pwdata,
   output logic [CSR_DATA_W-1:0]         prdata,
   output logic                          pready
);

   cfg_type      cfg;
   req_item_type in_word_ff, in_word_in;
   logic         in_valid_ff, in_valid_in;
   rsp_item_type out_word_ff, out_word_in;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type result;
   logic         accept;
   logic         advance;

   pidc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pidc_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .step   (advance),
      .item   (in_word_ff),
      .result (result)
   );

   // Handshake: move the input word on whenever the result register is free
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // Input register
   always_comb begin
      in_word_in  = in_word_ff;
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_word_in.cmd         = req_cmd;
         in_word_in.now_ms      = req_now_ms;
         in_word_in.measurement = req_measurement;
         in_word_in.setpoint    = req_setpoint;
         in_word_in.init_output = req_init_output;
         in_valid_in            = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Result register: load on advance, drop once taken
   always_comb begin
      out_word_in  = out_word_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_word_in  = result;
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_word_ff  <= in_word_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_drive   = out_word_ff.drive;
   assign rsp_updated = out_word_ff.updated;

endmodule

[rtl/core/pidc_checker.sv]
// ----------------------------------------------------------------------------
// PID controller port checker
// Watches the unit's ports for handshake and flow-through slips.
// ----------------------------------------------------------------------------
module pidc_checker import pidc_pkg::*; (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [SIGNAL_BITS-1:0] rsp_drive,
   input logic                          rsp_updated
);

   // A stalled result word stays and holds its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_drive) && $stable(rsp_updated))
      else $error("stalled result word changed or dropped");

   // Back-pressure on the input only ever comes from a stalled output
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_stall)
      else $error("input stalled while output is free");

   // An accepted word reaches the output through the input and result registers when the output flows
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
      else $error("accepted word did not reach the output");

   // Reset empties both registers
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("unit not empty after reset");

endmodule

bind pid_controller_unit pidc_checker u_pidc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_drive   (rsp_drive),
   .rsp_updated (rsp_updated)
);
